// File: rtl/cvs_pkg.sv
// Shared constants, types and helper functions for the streaming 2D correlation block.
package cvs_pkg;

    // Kernel and image limits.
    localparam int KERNEL_H   = 7;
    localparam int KERNEL_W   = 5;
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;

    // Fixed field widths of the ports.
    localparam int DATA_W     = 16;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int ACC_W      = 40;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int TAP_ROW_W  = 3;
    localparam int TAP_COL_W  = 3;
    localparam int OUT_ROW_W  = 6;
    localparam int OUT_COL_W  = 6;

    // Dimension registers after reset.
    localparam int RESET_WIDTH  = 28;
    localparam int RESET_HEIGHT = 28;

    // Position counters and dimension arithmetic.
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DIM_RAW = $clog2(MAX_DIM + 1);
    localparam int DIM_W   = (DIM_RAW > CFG_DATA_W) ? DIM_RAW : CFG_DATA_W;

    // Line buffer: each column keeps the last KERNEL_H-1 samples in one RAM word.
    localparam int LB_ROWS = (KERNEL_H > 1) ? KERNEL_H - 1 : 1;
    localparam int LB_W    = LB_ROWS * DATA_W;

    // Multiply and adder tree.
    localparam int NPROD       = KERNEL_H * KERNEL_W;
    localparam int NODES       = NPROD + 1;
    localparam int TREE_LEVELS = (NPROD > 1) ? $clog2(NPROD) : 1;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // Request type of an input word.
    typedef enum logic {
        REQ_COEF  = 1'b0,
        REQ_PIXEL = 1'b1
    } req_type_t;

    // Classified word as it travels through the queue.
    typedef struct packed {
        logic                        is_pixel;
        logic                        tap_ok;
        logic [TAP_ROW_W-1:0]        tap_row;
        logic [TAP_COL_W-1:0]        tap_col;
        logic [COL_W-1:0]            col;
        logic                        emit;
        logic                        last;
        logic [OUT_ROW_W-1:0]        out_row;
        logic [OUT_COL_W-1:0]        out_col;
        logic signed [DATA_W-1:0]    data;
    } item_t;

    // Tag that follows an emitting pixel down the arithmetic pipeline.
    typedef struct packed {
        logic                        valid;
        logic                        last;
        logic [OUT_ROW_W-1:0]        out_row;
        logic [OUT_COL_W-1:0]        out_col;
    } tag_t;

    // Saturate a dimension register into [lo, hi].
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v,
                                                   input int lo, input int hi);
        logic [DIM_W-1:0] ext;
        ext = DIM_W'(v);
        if (ext < DIM_W'(lo)) begin
            return DIM_W'(lo);
        end else if (ext > DIM_W'(hi)) begin
            return DIM_W'(hi);
        end
        return ext;
    endfunction

    // Number of live nodes on a level of the adder tree.
    function automatic int tree_cnt(input int level);
        int n;
        n = NPROD;
        for (int l = 0; l < level; l++) begin
            n = (n + 1) >> 1;
        end
        return n;
    endfunction

endpackage

// File: rtl/cvs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cvs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port; a read of the address being written sees old data.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/cvs_front.sv
// Front end: dimension registers, raster position tracking and word classification.
module cvs_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [cvs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cvs_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               push,
    input  logic                               s_req_type,
    input  logic [cvs_pkg::TAP_ROW_W-1:0]      s_tap_row,
    input  logic [cvs_pkg::TAP_COL_W-1:0]      s_tap_col,
    input  logic signed [cvs_pkg::DATA_W-1:0]  s_tap_value,
    input  logic signed [cvs_pkg::DATA_W-1:0]  s_pixel,
    output cvs_pkg::item_t                     item
);

    logic [cvs_pkg::CFG_DATA_W-1:0] width_reg;
    logic [cvs_pkg::CFG_DATA_W-1:0] height_reg;
    logic [cvs_pkg::ROW_W-1:0]      row_reg;
    logic [cvs_pkg::COL_W-1:0]      col_reg;
    logic [cvs_pkg::ROW_W-1:0]      row_next;
    logic [cvs_pkg::COL_W-1:0]      col_next;

    logic [cvs_pkg::DIM_W-1:0] eff_w;
    logic [cvs_pkg::DIM_W-1:0] eff_h;
    logic [cvs_pkg::DIM_W-1:0] row_inc;
    logic [cvs_pkg::DIM_W-1:0] col_inc;
    logic                      is_pixel;

    // Effective frame size and the position of the incoming pixel.
    always_comb begin
        eff_w    = cvs_pkg::clamp_dim(width_reg, cvs_pkg::KERNEL_W, cvs_pkg::MAX_WIDTH);
        eff_h    = cvs_pkg::clamp_dim(height_reg, cvs_pkg::KERNEL_H, cvs_pkg::MAX_HEIGHT);
        row_inc  = cvs_pkg::DIM_W'(row_reg) + cvs_pkg::DIM_W'(1);
        col_inc  = cvs_pkg::DIM_W'(col_reg) + cvs_pkg::DIM_W'(1);
        is_pixel = (cvs_pkg::req_type_t'(s_req_type) == cvs_pkg::REQ_PIXEL);
    end

    // Raster advance with wrap at the end of a row and of the frame.
    always_comb begin
        col_next = cvs_pkg::COL_W'(col_inc);
        row_next = row_reg;
        if (col_inc >= eff_w) begin
            col_next = '0;
            if (row_inc >= eff_h) begin
                row_next = '0;
            end else begin
                row_next = cvs_pkg::ROW_W'(row_inc);
            end
        end
    end

    // Classified word for the queue.
    always_comb begin
        item.is_pixel = is_pixel;
        item.tap_ok   = (int'(s_tap_row) < cvs_pkg::KERNEL_H) &&
                        (int'(s_tap_col) < cvs_pkg::KERNEL_W);
        item.tap_row  = s_tap_row;
        item.tap_col  = s_tap_col;
        item.col      = col_reg;
        item.emit     = (row_inc >= cvs_pkg::DIM_W'(cvs_pkg::KERNEL_H)) &&
                        (col_inc >= cvs_pkg::DIM_W'(cvs_pkg::KERNEL_W));
        item.last     = (row_inc == eff_h) && (col_inc == eff_w);
        item.out_row  = cvs_pkg::OUT_ROW_W'(row_inc - cvs_pkg::DIM_W'(cvs_pkg::KERNEL_H));
        item.out_col  = cvs_pkg::OUT_COL_W'(col_inc - cvs_pkg::DIM_W'(cvs_pkg::KERNEL_W));
        item.data     = is_pixel ? s_pixel : s_tap_value;
    end

    // Dimension registers and position counters; a register write restarts the frame.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= cvs_pkg::CFG_DATA_W'(cvs_pkg::RESET_WIDTH);
            height_reg <= cvs_pkg::CFG_DATA_W'(cvs_pkg::RESET_HEIGHT);
            row_reg    <= '0;
            col_reg    <= '0;
        end else if (cfg_wr_en) begin
            case (cvs_pkg::cfg_reg_t'(cfg_index))
                cvs_pkg::REG_IMAGE_WIDTH: begin
                    width_reg <= cfg_data;
                end
                cvs_pkg::REG_IMAGE_HEIGHT: begin
                    height_reg <= cfg_data;
                end
                default: begin
                end
            endcase
            row_reg <= '0;
            col_reg <= '0;
        end else if (push && is_pixel) begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

// File: rtl/cvs_queue.sv
// Short FIFO of classified words between the front end and the back end.
module cvs_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  cvs_pkg::item_t push_item,
    input  logic           pop,
    output cvs_pkg::item_t head,
    output logic           full,
    output logic           empty
);

    cvs_pkg::item_t                 mem_reg [cvs_pkg::QUEUE_DEPTH];
    logic [cvs_pkg::QUEUE_AW-1:0]   wr_ptr_reg;
    logic [cvs_pkg::QUEUE_AW-1:0]   rd_ptr_reg;
    logic [cvs_pkg::QUEUE_CW-1:0]   count_reg;

    assign full  = (count_reg == cvs_pkg::QUEUE_CW'(cvs_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + cvs_pkg::QUEUE_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + cvs_pkg::QUEUE_AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + cvs_pkg::QUEUE_CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - cvs_pkg::QUEUE_CW'(1);
            end
        end
    end

endmodule

// File: rtl/cvs_window.sv
// Back end, first half: line buffer RAM, sliding window and kernel tap registers.
module cvs_window (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               adv,
    input  logic                               q_empty,
    input  cvs_pkg::item_t                     q_head,
    output logic                               pop,
    output logic signed [cvs_pkg::DATA_W-1:0]  win [cvs_pkg::KERNEL_H][cvs_pkg::KERNEL_W],
    output logic signed [cvs_pkg::DATA_W-1:0]  coef [cvs_pkg::KERNEL_H][cvs_pkg::KERNEL_W],
    output cvs_pkg::tag_t                      tag
);

    logic                               s1_valid_reg;
    cvs_pkg::item_t                     s1_item_reg;
    logic                               byp_valid_reg;
    logic [cvs_pkg::LB_W-1:0]           byp_data_reg;
    cvs_pkg::tag_t                      tag_reg;
    logic signed [cvs_pkg::DATA_W-1:0]  win_reg  [cvs_pkg::KERNEL_H][cvs_pkg::KERNEL_W];
    logic signed [cvs_pkg::DATA_W-1:0]  coef_reg [cvs_pkg::KERNEL_H][cvs_pkg::KERNEL_W];

    logic [cvs_pkg::LB_W-1:0]           rd_data;
    logic [cvs_pkg::LB_W-1:0]           col_data;
    logic [cvs_pkg::LB_W-1:0]           lb_wr_data;
    logic                               lb_wr_en;
    logic signed [cvs_pkg::DATA_W-1:0]  hist    [cvs_pkg::LB_ROWS];
    logic signed [cvs_pkg::DATA_W-1:0]  new_col [cvs_pkg::KERNEL_H];

    assign pop      = adv && !q_empty;
    assign lb_wr_en = adv && s1_valid_reg && s1_item_reg.is_pixel;

    // Column history, one RAM word per image column.
    cvs_ram #(
        .WIDTH (cvs_pkg::LB_W),
        .DEPTH (cvs_pkg::MAX_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (lb_wr_en),
        .wr_addr (s1_item_reg.col),
        .wr_data (lb_wr_data),
        .rd_en   (adv),
        .rd_addr (q_head.col),
        .rd_data (rd_data)
    );

    // Column read with forwarding of a write to the same column on the read edge.
    always_comb begin
        col_data = byp_valid_reg ? byp_data_reg : rd_data;
        for (int a = 0; a < cvs_pkg::LB_ROWS; a++) begin
            hist[a] = col_data[a*cvs_pkg::DATA_W +: cvs_pkg::DATA_W];
        end
    end

    // New window column and the shifted history written back for this column.
    always_comb begin
        for (int a = 0; a < cvs_pkg::KERNEL_H; a++) begin
            if (a < cvs_pkg::KERNEL_H - 1) begin
                new_col[a] = hist[(a < cvs_pkg::LB_ROWS) ? a : 0];
            end else begin
                new_col[a] = s1_item_reg.data;
            end
        end
        for (int a = 0; a < cvs_pkg::LB_ROWS; a++) begin
            if (a + 1 < cvs_pkg::KERNEL_H - 1) begin
                lb_wr_data[a*cvs_pkg::DATA_W +: cvs_pkg::DATA_W] =
                    hist[(a + 1 < cvs_pkg::LB_ROWS) ? a + 1 : 0];
            end else begin
                lb_wr_data[a*cvs_pkg::DATA_W +: cvs_pkg::DATA_W] = s1_item_reg.data;
            end
        end
    end

    // Stage register behind the queue pop, with the forwarding flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg  <= pop;
            byp_valid_reg <= lb_wr_en && pop && (s1_item_reg.col == q_head.col);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_item_reg  <= q_head;
            byp_data_reg <= lb_wr_data;
        end
    end

    // Window shift on a pixel, tap write on an in-range coefficient word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
            for (int a = 0; a < cvs_pkg::KERNEL_H; a++) begin
                for (int b = 0; b < cvs_pkg::KERNEL_W; b++) begin
                    win_reg[a][b]  <= '0;
                    coef_reg[a][b] <= '0;
                end
            end
        end else if (adv) begin
            tag_reg.valid   <= s1_valid_reg && s1_item_reg.is_pixel && s1_item_reg.emit;
            tag_reg.last    <= s1_item_reg.last;
            tag_reg.out_row <= s1_item_reg.out_row;
            tag_reg.out_col <= s1_item_reg.out_col;
            if (s1_valid_reg && s1_item_reg.is_pixel) begin
                for (int a = 0; a < cvs_pkg::KERNEL_H; a++) begin
                    for (int b = 0; b < cvs_pkg::KERNEL_W; b++) begin
                        if (b < cvs_pkg::KERNEL_W - 1) begin
                            win_reg[a][b] <= win_reg[a][(b + 1 < cvs_pkg::KERNEL_W) ? b + 1 : b];
                        end else begin
                            win_reg[a][b] <= new_col[a];
                        end
                    end
                end
            end
            if (s1_valid_reg && !s1_item_reg.is_pixel && s1_item_reg.tap_ok) begin
                for (int a = 0; a < cvs_pkg::KERNEL_H; a++) begin
                    for (int b = 0; b < cvs_pkg::KERNEL_W; b++) begin
                        if ((int'(s1_item_reg.tap_row) == a) &&
                            (int'(s1_item_reg.tap_col) == b)) begin
                            coef_reg[a][b] <= s1_item_reg.data;
                        end
                    end
                end
            end
        end
    end

    assign win  = win_reg;
    assign coef = coef_reg;
    assign tag  = tag_reg;

endmodule

// File: rtl/cvs_mac.sv
// Back end, second half: tap products, registered adder tree and the result register.
module cvs_mac (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic signed [cvs_pkg::DATA_W-1:0]  win [cvs_pkg::KERNEL_H][cvs_pkg::KERNEL_W],
    input  logic signed [cvs_pkg::DATA_W-1:0]  coef [cvs_pkg::KERNEL_H][cvs_pkg::KERNEL_W],
    input  cvs_pkg::tag_t                      tag_in,
    output logic                               adv,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [cvs_pkg::OUT_ROW_W-1:0]      m_out_row,
    output logic [cvs_pkg::OUT_COL_W-1:0]      m_out_col,
    output logic signed [cvs_pkg::ACC_W-1:0]   m_acc_sum,
    output logic                               m_frame_last
);

    logic signed [cvs_pkg::PROD_W-1:0] prod [cvs_pkg::NPROD];
    logic signed [cvs_pkg::ACC_W-1:0]  tree_reg [cvs_pkg::TREE_LEVELS+1][cvs_pkg::NODES];
    cvs_pkg::tag_t                     tag_reg  [cvs_pkg::TREE_LEVELS+1];

    logic                              m_valid_reg;
    logic [cvs_pkg::OUT_ROW_W-1:0]     m_row_reg;
    logic [cvs_pkg::OUT_COL_W-1:0]     m_col_reg;
    logic signed [cvs_pkg::ACC_W-1:0]  m_sum_reg;
    logic                              m_last_reg;

    // The whole back end moves whenever the result register can take a word.
    assign adv = !m_valid_reg || m_ready;

    // One multiplier per kernel tap.
    always_comb begin
        for (int a = 0; a < cvs_pkg::KERNEL_H; a++) begin
            for (int b = 0; b < cvs_pkg::KERNEL_W; b++) begin
                prod[a*cvs_pkg::KERNEL_W + b] = win[a][b] * coef[a][b];
            end
        end
    end

    // Product register followed by pairwise adder levels; dead nodes hold zero.
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < cvs_pkg::NPROD; i++) begin
                tree_reg[0][i] <= cvs_pkg::ACC_W'(prod[i]);
            end
            tree_reg[0][cvs_pkg::NPROD] <= '0;
            for (int l = 1; l <= cvs_pkg::TREE_LEVELS; l++) begin
                for (int i = 0; i < cvs_pkg::tree_cnt(l); i++) begin
                    tree_reg[l][i] <= tree_reg[l-1][2*i] + tree_reg[l-1][2*i+1];
                end
                for (int i = cvs_pkg::tree_cnt(l); i < cvs_pkg::NODES; i++) begin
                    tree_reg[l][i] <= '0;
                end
            end
        end
    end

    // Tag pipeline alongside the tree, then the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int l = 0; l <= cvs_pkg::TREE_LEVELS; l++) begin
                tag_reg[l] <= '0;
            end
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            tag_reg[0] <= tag_in;
            for (int l = 1; l <= cvs_pkg::TREE_LEVELS; l++) begin
                tag_reg[l] <= tag_reg[l-1];
            end
            m_valid_reg <= tag_reg[cvs_pkg::TREE_LEVELS].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_row_reg  <= tag_reg[cvs_pkg::TREE_LEVELS].out_row;
            m_col_reg  <= tag_reg[cvs_pkg::TREE_LEVELS].out_col;
            m_last_reg <= tag_reg[cvs_pkg::TREE_LEVELS].last;
            m_sum_reg  <= tree_reg[cvs_pkg::TREE_LEVELS][0];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_row    = m_row_reg;
    assign m_out_col    = m_col_reg;
    assign m_acc_sum    = m_sum_reg;
    assign m_frame_last = m_last_reg;

endmodule

// File: rtl/conv2d_valid_stream_unit.sv
// Top level of the streaming 2D valid cross-correlation block.
//
// Computes out(r,c) = sum of in(r+a,c+b)*k(a,b) over a 7 by 5 kernel with an exact
// 40-bit signed sum. Coefficient words (req_type 0) load one tap; pixel words
// (req_type 1) stream the image in raster order. Every pixel whose row and column
// complete a full kernel footprint yields one result word, in raster order, and the
// last result of the frame carries frame_last. The block takes one word per clock while
// its queue is not full: each column's history lives in one line buffer RAM word, read
// and written back once per pixel, and all 35 taps are multiplied in parallel into a
// registered adder tree. When nothing stalls, a pixel's result passes through the line
// buffer read, window stage, product stage, six adder levels and result register. A
// waiting result holds the whole back end; the four-word queue in front of it still
// takes up to four more words before the input stalls as well. The user must write image
// width and height through the configuration port only while the block is idle; the
// block does not enforce this. Each write restarts the frame but keeps taps and line buffers.
module conv2d_valid_stream_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [cvs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cvs_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_req_type,
    input  logic [cvs_pkg::TAP_ROW_W-1:0]      s_tap_row,
    input  logic [cvs_pkg::TAP_COL_W-1:0]      s_tap_col,
    input  logic signed [cvs_pkg::DATA_W-1:0]  s_tap_value,
    input  logic signed [cvs_pkg::DATA_W-1:0]  s_pixel,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [cvs_pkg::OUT_ROW_W-1:0]      m_out_row,
    output logic [cvs_pkg::OUT_COL_W-1:0]      m_out_col,
    output logic signed [cvs_pkg::ACC_W-1:0]   m_acc_sum,
    output logic                               m_frame_last
);

    logic                               push;
    logic                               pop;
    logic                               q_full;
    logic                               q_empty;
    logic                               adv;
    cvs_pkg::item_t                     front_item;
    cvs_pkg::item_t                     q_head;
    cvs_pkg::tag_t                      win_tag;
    logic signed [cvs_pkg::DATA_W-1:0]  win  [cvs_pkg::KERNEL_H][cvs_pkg::KERNEL_W];
    logic signed [cvs_pkg::DATA_W-1:0]  coef [cvs_pkg::KERNEL_H][cvs_pkg::KERNEL_W];

    // Input word handshake.
    assign s_ready = !q_full;
    assign push    = s_valid && s_ready;

    cvs_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .s_req_type  (s_req_type),
        .s_tap_row   (s_tap_row),
        .s_tap_col   (s_tap_col),
        .s_tap_value (s_tap_value),
        .s_pixel     (s_pixel),
        .item        (front_item)
    );

    cvs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    cvs_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .q_empty (q_empty),
        .q_head  (q_head),
        .pop     (pop),
        .win     (win),
        .coef    (coef),
        .tag     (win_tag)
    );

    cvs_mac u_mac (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .win          (win),
        .coef         (coef),
        .tag_in       (win_tag),
        .adv          (adv),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_row    (m_out_row),
        .m_out_col    (m_out_col),
        .m_acc_sum    (m_acc_sum),
        .m_frame_last (m_frame_last)
    );

endmodule

// File: dv/conv2d_valid_stream_unit_tb.sv
// Self-checking testbench for the streaming 2D valid correlation unit.
`timescale 1ns / 100ps

module conv2d_valid_stream_unit_tb;
    import cvs_pkg::*;

    localparam int SETTLE_CYCLES  = 32;
    localparam int TIMEOUT_NS     = 5_000_000;
    localparam int MAX_IDLE       = 10;
    localparam int WORD_TARGET    = 1350;
    localparam int SHOWN_ERRORS   = 10;
    localparam int RANDOM_PIX_MAX = 150;

    // Distributions for tap and pixel values.
    localparam int VAL_FULL  = 0;
    localparam int VAL_EDGE  = 1;
    localparam int VAL_SMALL = 2;
    localparam int VAL_MIN   = 3;
    localparam int VAL_MAX   = 4;

    localparam logic signed [DATA_W-1:0] SAMPLE_MIN = DATA_W'(-(2 ** (DATA_W - 1)));
    localparam logic signed [DATA_W-1:0] SAMPLE_MAX = DATA_W'(2 ** (DATA_W - 1) - 1);

    // One input word together with the idle cycles that precede it.
    typedef struct {
        req_type_t                kind;
        logic [TAP_ROW_W-1:0]     tap_row;
        logic [TAP_COL_W-1:0]     tap_col;
        logic signed [DATA_W-1:0] tap_value;
        logic signed [DATA_W-1:0] pixel;
        int                       gap;
    } word_t;

    // One completed output pixel.
    typedef struct packed {
        logic [OUT_ROW_W-1:0]    out_row;
        logic [OUT_COL_W-1:0]    out_col;
        logic signed [ACC_W-1:0] acc_sum;
        logic                    frame_last;
    } conv_result_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic                     s_req_type = REQ_COEF;
    logic [TAP_ROW_W-1:0]     s_tap_row = '0;
    logic [TAP_COL_W-1:0]     s_tap_col = '0;
    logic signed [DATA_W-1:0] s_tap_value = '0;
    logic signed [DATA_W-1:0] s_pixel = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [OUT_ROW_W-1:0]     m_out_row;
    logic [OUT_COL_W-1:0]     m_out_col;
    logic signed [ACC_W-1:0]  m_acc_sum;
    logic                     m_frame_last;

    // Words waiting to be sent and output pixels waiting to arrive.
    word_t        pending_words[$];
    conv_result_t expected_pixels[$];
    word_t        held_word;
    conv_result_t want_result;
    int           gap_count = 0;
    int           stall_left = 0;
    int           src_gap_max = 0;
    int           sink_stall_max = 0;
    int           words_issued = 0;
    int           error_count = 0;

    // Shadow copy of the correlator state.
    logic signed [DATA_W-1:0] tap_store [KERNEL_H][KERNEL_W];
    logic signed [DATA_W-1:0] col_hist [KERNEL_H][MAX_WIDTH];
    logic signed [DATA_W-1:0] win [KERNEL_H][KERNEL_W];
    logic [CFG_DATA_W-1:0]    frame_width;
    logic [CFG_DATA_W-1:0]    frame_height;
    int                       pos_row;
    int                       pos_col;

    conv2d_valid_stream_unit u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_tap_row    (s_tap_row),
        .s_tap_col    (s_tap_col),
        .s_tap_value  (s_tap_value),
        .s_pixel      (s_pixel),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_row    (m_out_row),
        .m_out_col    (m_out_col),
        .m_acc_sum    (m_acc_sum),
        .m_frame_last (m_frame_last)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Saturate a dimension register to the range the block supports.
    function automatic int fit_dim(input logic [CFG_DATA_W-1:0] value, input int lo,
                                   input int hi);
        if (int'(value) < lo) return lo;
        if (int'(value) > hi) return hi;
        return int'(value);
    endfunction

    function automatic void clear_model();
        for (int a = 0; a < KERNEL_H; a++) begin
            for (int b = 0; b < KERNEL_W; b++) begin
                tap_store[a][b] = '0;
                win[a][b]       = '0;
            end
            for (int c = 0; c < MAX_WIDTH; c++) begin
                col_hist[a][c] = '0;
            end
        end
        frame_width  = CFG_DATA_W'(RESET_WIDTH);
        frame_height = CFG_DATA_W'(RESET_HEIGHT);
        pos_row      = 0;
        pos_col      = 0;
    endfunction

    // Apply one accepted word to the shadow state and queue the pixel it completes.
    function automatic void correlate_word(input word_t wd);
        int           w;
        int           h;
        longint       acc;
        conv_result_t res;
        if (wd.kind == REQ_COEF) begin
            if (int'(wd.tap_row) < KERNEL_H && int'(wd.tap_col) < KERNEL_W) begin
                tap_store[wd.tap_row][wd.tap_col] = wd.tap_value;
            end
        end else begin
            w = fit_dim(frame_width, KERNEL_W, MAX_WIDTH);
            h = fit_dim(frame_height, KERNEL_H, MAX_HEIGHT);
            // Push the new sample into its column history.
            for (int a = 0; a < KERNEL_H - 1; a++) begin
                col_hist[a][pos_col] = col_hist[a + 1][pos_col];
            end
            col_hist[KERNEL_H - 1][pos_col] = wd.pixel;
            // Slide the window one column and take in the updated column.
            for (int a = 0; a < KERNEL_H; a++) begin
                for (int b = 0; b < KERNEL_W - 1; b++) begin
                    win[a][b] = win[a][b + 1];
                end
                win[a][KERNEL_W - 1] = col_hist[a][pos_col];
            end
            if (pos_row >= KERNEL_H - 1 && pos_col >= KERNEL_W - 1) begin
                acc = 64'sd0;
                for (int a = 0; a < KERNEL_H; a++) begin
                    for (int b = 0; b < KERNEL_W; b++) begin
                        acc += longint'(win[a][b]) * longint'(tap_store[a][b]);
                    end
                end
                res.out_row    = OUT_ROW_W'(pos_row - (KERNEL_H - 1));
                res.out_col    = OUT_COL_W'(pos_col - (KERNEL_W - 1));
                res.acc_sum    = acc[ACC_W-1:0];
                res.frame_last = (pos_row == h - 1) && (pos_col == w - 1);
                expected_pixels.push_back(res);
            end
            // Advance the raster position, wrapping at the end of the frame.
            pos_col++;
            if (pos_col >= w) begin
                pos_col = 0;
                pos_row++;
                if (pos_row >= h) begin
                    pos_row = 0;
                end
            end
        end
    endfunction

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= SHOWN_ERRORS) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] draw_sample(input int mode);
        logic signed [DATA_W-1:0] corner [4] = '{SAMPLE_MIN, SAMPLE_MAX, '0, '1};
        case (mode)
            VAL_EDGE:  return corner[$urandom_range(0, 3)];
            VAL_SMALL: return DATA_W'(int'($urandom_range(0, 8)) - 4);
            VAL_MIN:   return SAMPLE_MIN;
            VAL_MAX:   return SAMPLE_MAX;
            default:   return DATA_W'($urandom);
        endcase
    endfunction

    // Coefficient word; the unused pixel field carries noise.
    function automatic word_t make_coef(input int row, input int col,
                                        input logic signed [DATA_W-1:0] value);
        word_t wd;
        wd.kind      = REQ_COEF;
        wd.tap_row   = TAP_ROW_W'(row);
        wd.tap_col   = TAP_COL_W'(col);
        wd.tap_value = value;
        wd.pixel     = DATA_W'($urandom);
        wd.gap       = 0;
        return wd;
    endfunction

    // Pixel word; the unused tap fields carry noise.
    function automatic word_t make_pixel(input logic signed [DATA_W-1:0] value);
        word_t wd;
        wd.kind      = REQ_PIXEL;
        wd.tap_row   = TAP_ROW_W'($urandom);
        wd.tap_col   = TAP_COL_W'($urandom);
        wd.tap_value = DATA_W'($urandom);
        wd.pixel     = value;
        wd.gap       = 0;
        return wd;
    endfunction

    function automatic void queue_word(input word_t wd);
        wd.gap = int'($urandom_range(0, src_gap_max));
        pending_words.push_back(wd);
        words_issued++;
    endfunction

    // A full kernel in raster order, or a number of writes to random positions,
    // roughly half of which fall outside the kernel.
    function automatic void load_taps(input int mode, input int count);
        if (count >= NPROD) begin
            for (int a = 0; a < KERNEL_H; a++) begin
                for (int b = 0; b < KERNEL_W; b++) begin
                    queue_word(make_coef(a, b, draw_sample(mode)));
                end
            end
        end else begin
            repeat (count) begin
                queue_word(make_coef($urandom_range(0, 7), $urandom_range(0, 7),
                                     draw_sample(mode)));
            end
        end
    endfunction

    // Pixels in raster order, with stray coefficient words mixed in.
    function automatic void stream_pixels(input int count, input int mode, input int noise_pct);
        repeat (count) begin
            if ($urandom_range(0, 99) < noise_pct) begin
                queue_word(make_coef($urandom_range(0, 7), $urandom_range(0, 7),
                                     draw_sample(VAL_FULL)));
            end
            queue_word(make_pixel(draw_sample(mode)));
        end
    endfunction

    function automatic void set_idling(input int src_max, input int sink_max);
        src_gap_max    = src_max;
        sink_stall_max = sink_max;
    endfunction

    // Hold off until every word is taken and every output pixel has arrived.
    task automatic wait_idle();
        do begin
            @(negedge aclk);
        end while (pending_words.size() != 0 || s_valid || expected_pixels.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Write a dimension register; the frame restarts at the write edge.
    task automatic write_dim(input cfg_reg_t index, input logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (index == REG_IMAGE_WIDTH) begin
            frame_width = value;
        end else begin
            frame_height = value;
        end
        pos_row = 0;
        pos_col = 0;
        @(negedge aclk);
    endtask

    // Input driver: predicts each accepted word, then presents the next one
    // after its idle gap.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            gap_count = 0;
        end else begin
            if (s_valid && s_ready) begin
                correlate_word(held_word);
            end
            if (!s_valid || s_ready) begin
                if (pending_words.size() != 0 && gap_count >= pending_words[0].gap) begin
                    held_word = pending_words.pop_front();
                    gap_count = 0;
                    s_valid     <= 1'b1;
                    s_req_type  <= held_word.kind;
                    s_tap_row   <= held_word.tap_row;
                    s_tap_col   <= held_word.tap_col;
                    s_tap_value <= held_word.tap_value;
                    s_pixel     <= held_word.pixel;
                end else begin
                    if (pending_words.size() != 0) begin
                        gap_count++;
                    end
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: checks each accepted word against the oldest prediction,
    // then stalls a random number of cycles before taking the next one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    note_error($sformatf("unexpected word: row %0d col %0d sum %0d last %0b",
                                         m_out_row, m_out_col, m_acc_sum, m_frame_last));
                end else begin
                    want_result = expected_pixels.pop_front();
                    if (m_out_row !== want_result.out_row ||
                        m_out_col !== want_result.out_col ||
                        m_acc_sum !== want_result.acc_sum ||
                        m_frame_last !== want_result.frame_last) begin
                        note_error($sformatf({"mismatch: expected row %0d col %0d sum %0d ",
                                              "last %0b, got row %0d col %0d sum %0d last %0b"},
                                             want_result.out_row, want_result.out_col,
                                             want_result.acc_sum, want_result.frame_last,
                                             m_out_row, m_out_col, m_acc_sum, m_frame_last));
                    end
                end
                stall_left = int'($urandom_range(0, sink_stall_max));
            end else if (m_valid && stall_left > 0) begin
                stall_left--;
            end
            m_ready <= (stall_left == 0);
        end
    end

    // Stimulus sequence.
    initial begin
        int area;
        int random_phases;
        int pix_mode;
        int pix_count;
        random_phases = 0;
        clear_model();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset dimensions: a full kernel, then taps at the value extremes and
        // writes outside the kernel that must leave the taps alone.
        set_idling(MAX_IDLE, MAX_IDLE);
        load_taps(VAL_FULL, NPROD);
        queue_word(make_coef(0, 0, SAMPLE_MAX));
        queue_word(make_coef(KERNEL_H - 1, KERNEL_W - 1, SAMPLE_MIN));
        queue_word(make_coef(0, KERNEL_W - 1, '1));
        queue_word(make_coef(KERNEL_H - 1, 0, DATA_W'(1)));
        queue_word(make_coef(3, 2, '0));
        queue_word(make_coef(KERNEL_H, 0, draw_sample(VAL_FULL)));
        queue_word(make_coef(0, KERNEL_W, draw_sample(VAL_FULL)));
        queue_word(make_coef(7, 7, draw_sample(VAL_FULL)));
        queue_word(make_coef(3, 6, draw_sample(VAL_FULL)));
        queue_word(make_coef(KERNEL_H - 1, KERNEL_W, draw_sample(VAL_FULL)));
        stream_pixels(RESET_WIDTH * KERNEL_H, VAL_FULL, 0);
        wait_idle();

        // Width below the kernel, reset height: largest positive sums, frame wrap.
        set_idling(0, MAX_IDLE);
        write_dim(REG_IMAGE_WIDTH, '0);
        load_taps(VAL_MIN, NPROD);
        stream_pixels(KERNEL_W * (RESET_HEIGHT + KERNEL_H), VAL_MIN, 0);
        wait_idle();

        // Height below the kernel, widest frame, full rate on both sides.
        set_idling(0, 0);
        write_dim(REG_IMAGE_HEIGHT, 7'd3);
        write_dim(REG_IMAGE_WIDTH, CFG_DATA_W'(MAX_WIDTH));
        load_taps(VAL_EDGE, NPROD);
        stream_pixels(MAX_WIDTH * KERNEL_H, VAL_FULL, 5);
        wait_idle();

        // Narrowest width, height above the limit: largest negative sums.
        set_idling(MAX_IDLE, 0);
        write_dim(REG_IMAGE_WIDTH, CFG_DATA_W'(KERNEL_W));
        write_dim(REG_IMAGE_HEIGHT, '1);
        load_taps(VAL_MIN, NPROD);
        stream_pixels(KERNEL_W * MAX_HEIGHT, VAL_MAX, 0);
        wait_idle();

        // Random small frames, mostly well formed, some restarted mid-frame and
        // some continued across phases without a restart.
        while (random_phases < 2 || words_issued < WORD_TARGET) begin
            random_phases++;
            set_idling(($urandom_range(0, 2) == 0) ? 0 : MAX_IDLE,
                       ($urandom_range(0, 2) == 0) ? 0 : MAX_IDLE);
            if ($urandom_range(0, 3) != 0) begin
                wait_idle();
                if ($urandom_range(0, 1) != 0) begin
                    write_dim(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(0, 12)));
                end
                write_dim(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(0, 12)));
            end
            load_taps(($urandom_range(0, 2) == 0) ? $urandom_range(VAL_EDGE, VAL_MAX) : VAL_FULL,
                      $urandom_range(0, NPROD));
            pix_mode = ($urandom_range(0, 3) == 0) ? $urandom_range(VAL_EDGE, VAL_MAX)
                                                   : VAL_FULL;
            area = fit_dim(frame_width, KERNEL_W, MAX_WIDTH) *
                   fit_dim(frame_height, KERNEL_H, MAX_HEIGHT);
            pix_count = area + int'($urandom_range(0, area));
            if (pix_count > RANDOM_PIX_MAX) begin
                pix_count = RANDOM_PIX_MAX;
            end
            stream_pixels(pix_count, pix_mode, 8);
        end
        wait_idle();

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
